>>> sv/swmq_pkg.sv
// Shared constants, codes and helper functions for the stack with median query.
package swmq_pkg;

   localparam int VALUE_RANGE = 1024;
   localparam int BUCKET_SIZE = 32;
   localparam int STACK_DEPTH = 1024;

   localparam int NUM_BUCKETS = (VALUE_RANGE + BUCKET_SIZE - 1) / BUCKET_SIZE;

   localparam int IN_W   = 10;
   localparam int RV_W   = 10;
   localparam int VAL_W  = $clog2(VALUE_RANGE);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int PTR_W  = $clog2(STACK_DEPTH);
   localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int OFF_W  = $clog2(BUCKET_SIZE + 1);
   localparam int BS_LOG = $clog2(BUCKET_SIZE);
   localparam int STRT_W = VAL_W + BS_LOG + 1;

   // x / BUCKET_SIZE as a multiply by a rounded-up reciprocal, exact for x < 2**VAL_W
   localparam int DIV_SH  = VAL_W + BS_LOG;
   localparam int DIV_M   = (2 ** DIV_SH + BUCKET_SIZE - 1) / BUCKET_SIZE;
   localparam int MUL_W   = 2 * VAL_W + 4;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_FULL  = 2'd2
   } status_type;

   function automatic logic [VAL_W-1:0] sat_value(input logic [IN_W-1:0] pv);
      logic [31:0] w;
      w = 32'(pv);
      if (w >= 32'(VALUE_RANGE)) begin
         w = 32'(VALUE_RANGE - 1);
      end
      return w[VAL_W-1:0];
   endfunction

   function automatic logic [BKT_W-1:0] bucket_of(input logic [VAL_W-1:0] x);
      logic [MUL_W-1:0] p;
      p = MUL_W'(x) * MUL_W'(DIV_M);
      return p[DIV_SH +: BKT_W];
   endfunction

endpackage

>>> sv/stack_with_median_query.sv
// Top level: LIFO stack with per-value and per-bucket histograms for median queries.
//
//  channel | dir | handshake                  | payload
//  req_    | in  | req_tvalid / req_tready    | tuser: opcode, tdata: push_value
//  rsp_    | out | rsp_tvalid / rsp_tready    | tuser: status, tdata: result_value
//
// Push runs through PUSH_RD and CNT_WR, pop through POP_RD, CNT_WR and DONE, an error
// result through DONE. Peek walks the bucket RAM and then the value RAM one read per cycle.
// After reset a clearing pass zeroes both count RAMs over all VALUE_RANGE addresses, with
// req_tready low. One transaction is in work at a time; a result waits in the
// output register while the next request is taken.
module stack_with_median_query
   import swmq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] push_value, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [9:0] result_value, rest zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   typedef enum logic [7:0] {
      S_CLEAR   = 8'b00000001,
      S_IDLE    = 8'b00000010,
      S_PUSH_RD = 8'b00000100,
      S_POP_RD  = 8'b00001000,
      S_CNT_WR  = 8'b00010000,
      S_MED_B   = 8'b00100000,
      S_MED_V   = 8'b01000000,
      S_DONE    = 8'b10000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [VAL_W-1:0] x_ff, x_in;
   logic [BKT_W-1:0] bidx_ff, bidx_in;
   logic             is_pop_ff, is_pop_in;
   logic [CNT_W-1:0] target_ff, target_in;
   logic [CNT_W-1:0] sum_ff, sum_in;
   logic [BKT_W-1:0] b_ff, b_in;
   logic [VAL_W-1:0] v_ff, v_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic [VAL_W-1:0] clr_ff, clr_in;
   status_type       res_status_ff, res_status_in;
   logic [VAL_W-1:0] res_value_ff, res_value_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [RV_W-1:0]  rsp_value_ff, rsp_value_in;

   logic             stk_we;
   logic [PTR_W-1:0] stk_waddr, stk_raddr;
   logic [VAL_W-1:0] stk_wdata, stk_rdata;
   logic             bkt_we;
   logic [BKT_W-1:0] bkt_waddr, bkt_raddr;
   logic [CNT_W-1:0] bkt_wdata, bkt_rdata;
   logic             val_we;
   logic [VAL_W-1:0] val_waddr, val_raddr;
   logic [CNT_W-1:0] val_wdata, val_rdata;

   logic             accept;
   opcode_type       op;
   logic [CNT_W:0]   bsum, vsum;
   logic             b_more, v_more;
   logic [STRT_W-1:0] b_start;
   logic             rsp_load;

   swmq_ram #(.WIDTH(VAL_W), .DEPTH(STACK_DEPTH), .AW(PTR_W)) u_stack_ram (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
      .rd_addr(stk_raddr), .rd_data(stk_rdata)
   );

   swmq_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BUCKETS), .AW(BKT_W)) u_bucket_ram (
      .clock(clock), .wr_en(bkt_we), .wr_addr(bkt_waddr), .wr_data(bkt_wdata),
      .rd_addr(bkt_raddr), .rd_data(bkt_rdata)
   );

   swmq_ram #(.WIDTH(CNT_W), .DEPTH(VALUE_RANGE), .AW(VAL_W)) u_value_ram (
      .clock(clock), .wr_en(val_we), .wr_addr(val_waddr), .wr_data(val_wdata),
      .rd_addr(val_raddr), .rd_data(val_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign op         = opcode_type'(req_tuser);

   assign bsum    = (CNT_W+1)'(sum_ff) + (CNT_W+1)'(bkt_rdata);
   assign vsum    = (CNT_W+1)'(sum_ff) + (CNT_W+1)'(val_rdata);
   assign b_more  = ((BKT_W+1)'(b_ff) + 1'b1) < (BKT_W+1)'(NUM_BUCKETS);
   assign v_more  = (((OFF_W+1)'(off_ff) + 1'b1) < (OFF_W+1)'(BUCKET_SIZE))
                 && (((VAL_W+1)'(v_ff) + 1'b1) < (VAL_W+1)'(VALUE_RANGE));
   assign b_start = STRT_W'(b_ff) * STRT_W'(BUCKET_SIZE);
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      x_in          = x_ff;
      bidx_in       = bidx_ff;
      is_pop_in     = is_pop_ff;
      target_in     = target_ff;
      sum_in        = sum_ff;
      b_in          = b_ff;
      v_in          = v_ff;
      off_in        = off_ff;
      clr_in        = clr_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;

      stk_we    = 1'b0;
      stk_waddr = count_ff[PTR_W-1:0];
      stk_wdata = sat_value(req_tdata[IN_W-1:0]);
      stk_raddr = PTR_W'(count_ff - 1'b1);
      bkt_we    = 1'b0;
      bkt_waddr = bidx_ff;
      bkt_wdata = '0;
      bkt_raddr = '0;
      val_we    = 1'b0;
      val_waddr = x_ff;
      val_wdata = '0;
      val_raddr = x_ff;

      case (state_ff)
         S_CLEAR: begin
            val_we    = 1'b1;
            val_waddr = clr_ff;
            val_wdata = '0;
            bkt_we    = (STRT_W'(clr_ff) < STRT_W'(NUM_BUCKETS));
            bkt_waddr = BKT_W'(clr_ff);
            bkt_wdata = '0;
            if (clr_ff == VAL_W'(VALUE_RANGE - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (op)
                  OP_PUSH: begin
                     if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                        res_status_in = STS_FULL;
                        res_value_in  = '0;
                        state_in      = S_DONE;
                     end else begin
                        stk_we    = 1'b1;
                        x_in      = sat_value(req_tdata[IN_W-1:0]);
                        count_in  = count_ff + 1'b1;
                        is_pop_in = 1'b0;
                        state_in  = S_PUSH_RD;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        res_status_in = STS_EMPTY;
                        res_value_in  = '0;
                        state_in      = S_DONE;
                     end else begin
                        count_in  = count_ff - 1'b1;
                        is_pop_in = 1'b1;
                        state_in  = S_POP_RD;
                     end
                  end
                  OP_PEEK: begin
                     if (count_ff == '0) begin
                        res_status_in = STS_EMPTY;
                        res_value_in  = '0;
                        state_in      = S_DONE;
                     end else begin
                        target_in = CNT_W'(((CNT_W+1)'(count_ff) + 1'b1) >> 1);
                        sum_in    = '0;
                        b_in      = '0;
                        bkt_raddr = '0;
                        state_in  = S_MED_B;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_PUSH_RD: begin
            bidx_in   = bucket_of(x_ff);
            bkt_raddr = bucket_of(x_ff);
            val_raddr = x_ff;
            state_in  = S_CNT_WR;
         end
         S_POP_RD: begin
            x_in      = stk_rdata;
            bidx_in   = bucket_of(stk_rdata);
            bkt_raddr = bucket_of(stk_rdata);
            val_raddr = stk_rdata;
            state_in  = S_CNT_WR;
         end
         S_CNT_WR: begin
            bkt_we    = 1'b1;
            bkt_waddr = bidx_ff;
            val_we    = 1'b1;
            val_waddr = x_ff;
            if (is_pop_ff) begin
               bkt_wdata     = (bkt_rdata == '0) ? bkt_rdata : bkt_rdata - 1'b1;
               val_wdata     = (val_rdata == '0) ? val_rdata : val_rdata - 1'b1;
               res_status_in = STS_OK;
               res_value_in  = x_ff;
               state_in      = S_DONE;
            end else begin
               bkt_wdata = bkt_rdata + 1'b1;
               val_wdata = val_rdata + 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_MED_B: begin
            bkt_raddr = b_ff + 1'b1;
            if (b_more && (bsum < (CNT_W+1)'(target_ff))) begin
               sum_in = bsum[CNT_W-1:0];
               b_in   = b_ff + 1'b1;
            end else begin
               v_in      = b_start[VAL_W-1:0];
               off_in    = '0;
               val_raddr = b_start[VAL_W-1:0];
               state_in  = S_MED_V;
            end
         end
         S_MED_V: begin
            val_raddr = v_ff + 1'b1;
            if (v_more && (vsum < (CNT_W+1)'(target_ff))) begin
               sum_in = vsum[CNT_W-1:0];
               v_in   = v_ff + 1'b1;
               off_in = off_ff + 1'b1;
            end else begin
               res_status_in = STS_OK;
               res_value_in  = v_ff;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_value_in  = RV_W'(res_value_ff);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      bidx_ff       <= bidx_in;
      is_pop_ff     <= is_pop_in;
      target_ff     <= target_in;
      sum_ff        <= sum_in;
      b_ff          <= b_in;
      v_ff          <= v_in;
      off_ff        <= off_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 16'(rsp_value_ff);
   assign rsp_tuser  = rsp_status_ff;

endmodule

>>> sv/swmq_ram.sv
// Generic simple dual-port RAM with registered read data.
module swmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> sv/swmq_checker.sv
// Port-level assertions for the stack with median query, bound to the top level.
module swmq_checker
   import swmq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp changed while stalled");

   // clearing pass blocks requests right after reset
   a_clear_blocks: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request ready during clearing pass");

   // one transaction at a time: a real command drops ready
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != OP_NONE) |=> !req_tready)
      else $error("ready stayed high after a command");

   // error results carry zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STS_EMPTY || rsp_tuser == STS_FULL) |-> rsp_tdata == '0)
      else $error("error result with nonzero value");

   // status code is always a defined one
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STS_OK || rsp_tuser == STS_EMPTY || rsp_tuser == STS_FULL))
      else $error("undefined status");

endmodule

bind stack_with_median_query swmq_checker u_swmq_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .req_tuser(req_tuser),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);

>>> test/tb_stack_with_median_query.sv
// Self-checking testbench for stack_with_median_query against a shadow stack and histograms.
module tb_stack_with_median_query;
   timeunit 1ns;
   timeprecision 1ps;

   import swmq_pkg::*;

   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 100;

   typedef struct {
      opcode_type       op;
      logic [IN_W-1:0]  value;
   } request_type;

   typedef struct {
      status_type       status;
      logic [RV_W-1:0]  value;
   } outcome_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [9:0] push_value, rest zero
   logic [1:0]  req_tuser  = '0;   // [1:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [9:0] result_value, rest zero
   logic [1:0]  rsp_tuser;         // [1:0] status

   request_type pending[$];
   outcome_type awaited[$];

   int send_idle    = 0;
   int recv_idle    = 0;
   int holds_asked  = 0;
   int holds_done   = 0;
   int hold_left    = 0;
   int quiet        = 0;
   int queued       = 0;
   int accepted     = 0;
   int checked      = 0;
   int failures     = 0;
   int plan_depth   = 0;
   int cluster_base = 0;
   int medians      = 0;
   int full_rejects = 0;
   int empty_errors = 0;
   int peak_depth   = 0;

   // shadow of the block
   logic [VAL_W-1:0] shadow_stack [STACK_DEPTH];
   int               depth = 0;
   int               value_tally  [VALUE_RANGE];
   int               bucket_tally [NUM_BUCKETS];

   always #2 clock = ~clock;

   stack_with_median_query uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   function automatic logic [VAL_W-1:0] stack_median();
      int goal;
      int seen;
      int b;
      int v;
      int stop;
      goal = (depth + 1) / 2;
      seen = 0;
      b    = 0;
      while (b + 1 < NUM_BUCKETS && seen + bucket_tally[b] < goal) begin
         seen += bucket_tally[b];
         b++;
      end
      v    = b * BUCKET_SIZE;
      stop = v + BUCKET_SIZE;
      if (stop > VALUE_RANGE) begin
         stop = VALUE_RANGE;
      end
      while (v + 1 < stop && seen + value_tally[v] < goal) begin
         seen += value_tally[v];
         v++;
      end
      return VAL_W'(v);
   endfunction

   task automatic predict_outcome(input opcode_type op, input logic [IN_W-1:0] raw);
      int          x;
      outcome_type o;
      o.status = STS_OK;
      o.value  = '0;
      case (op)
         OP_PUSH: begin
            if (depth >= STACK_DEPTH) begin
               o.status = STS_FULL;
               awaited.push_back(o);
               full_rejects++;
            end else begin
               x = raw;
               if (x >= VALUE_RANGE) begin
                  x = VALUE_RANGE - 1;
               end
               shadow_stack[depth] = VAL_W'(x);
               depth++;
               bucket_tally[x / BUCKET_SIZE]++;
               value_tally[x]++;
               if (depth > peak_depth) begin
                  peak_depth = depth;
               end
            end
         end
         OP_POP: begin
            if (depth == 0) begin
               o.status = STS_EMPTY;
               empty_errors++;
            end else begin
               depth--;
               x = shadow_stack[depth];
               if (bucket_tally[x / BUCKET_SIZE] > 0) begin
                  bucket_tally[x / BUCKET_SIZE]--;
               end
               if (value_tally[x] > 0) begin
                  value_tally[x]--;
               end
               o.value = RV_W'(x);
            end
            awaited.push_back(o);
         end
         OP_PEEK: begin
            if (depth == 0) begin
               o.status = STS_EMPTY;
               empty_errors++;
            end else begin
               o.value = RV_W'(stack_median());
               medians++;
            end
            awaited.push_back(o);
         end
         default: begin
         end
      endcase
   endtask

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      failures++;
   endtask

   function automatic int pick_value();
      int r;
      r = $urandom_range(9);
      if (r < 5) begin
         return $urandom_range(VALUE_RANGE - 1);
      end else if (r < 8) begin
         return cluster_base + $urandom_range(47);
      end
      case ($urandom_range(5))
         0:       return 0;
         1:       return BUCKET_SIZE - 1;
         2:       return BUCKET_SIZE;
         3:       return VALUE_RANGE - BUCKET_SIZE;
         default: return VALUE_RANGE - 1;
      endcase
   endfunction

   task automatic queue_item(input opcode_type op, input int value);
      request_type r;
      r.op    = op;
      r.value = IN_W'(value);
      pending.push_back(r);
      queued++;
      if (op == OP_PUSH && plan_depth < STACK_DEPTH) begin
         plan_depth++;
      end else if (op == OP_POP && plan_depth > 0) begin
         plan_depth--;
      end
   endtask

   task automatic random_items(input int count);
      int roll;
      int push_w;
      for (int i = 0; i < count; i++) begin
         if (i % 32 == 0) begin
            cluster_base = $urandom_range(VALUE_RANGE - 48);
         end
         roll   = $urandom_range(99);
         push_w = (plan_depth < 40) ? 45 : 25;
         if (roll < push_w) begin
            queue_item(OP_PUSH, pick_value());
         end else if (roll < push_w + 30) begin
            queue_item(OP_POP, $urandom_range(VALUE_RANGE - 1));
         end else if (roll < 95) begin
            queue_item(OP_PEEK, $urandom_range(VALUE_RANGE - 1));
         end else begin
            queue_item(OP_NONE, $urandom_range(VALUE_RANGE - 1));
         end
      end
   endtask

   task automatic wait_for_sender();
      while (pending.size() != 0) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin : driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending.size() != 0 && $urandom_range(99) >= send_idle) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending[0].op;
            req_tdata  <= 16'(pending[0].value);
            void'(pending.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : receiver
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_done != holds_asked) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin : monitor
      outcome_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            accepted++;
            predict_outcome(opcode_type'(req_tuser), req_tdata[IN_W-1:0]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited.size() == 0) begin
               report_mismatch($sformatf("result with nothing pending: status %0d data %0d",
                                         rsp_tuser, rsp_tdata));
            end else begin
               want = awaited.pop_front();
               checked++;
               if (rsp_tuser !== want.status) begin
                  report_mismatch($sformatf("status got %0d expected %0d (result %0d)",
                                            rsp_tuser, want.status, checked));
               end
               if (rsp_tdata !== 16'(want.value)) begin
                  report_mismatch($sformatf("value got %0d expected %0d (result %0d)",
                                            rsp_tdata, want.value, checked));
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("[%0t] timeout: no transaction for %0d cycles", $realtime, quiet);
            $display("stack_with_median_query test failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle = 23;
      recv_idle = 76;
      queue_item(OP_POP, 0);
      queue_item(OP_PEEK, VALUE_RANGE - 1);
      queue_item(OP_NONE, VALUE_RANGE - 1);
      queue_item(OP_PUSH, 0);
      queue_item(OP_PEEK, 0);
      queue_item(OP_PUSH, VALUE_RANGE - 1);
      queue_item(OP_PEEK, 0);
      queue_item(OP_PUSH, VALUE_RANGE - 1);
      queue_item(OP_PEEK, 0);
      queue_item(OP_PUSH, BUCKET_SIZE - 1);
      queue_item(OP_PUSH, BUCKET_SIZE);
      queue_item(OP_PEEK, 0);
      queue_item(OP_POP, 0);
      queue_item(OP_POP, 0);
      queue_item(OP_NONE, 0);
      queue_item(OP_POP, 0);
      queue_item(OP_POP, 0);
      queue_item(OP_POP, 0);
      queue_item(OP_POP, 0);
      queue_item(OP_PUSH, 682);
      queue_item(OP_PUSH, 341);
      queue_item(OP_PEEK, 0);
      queue_item(OP_POP, 0);
      queue_item(OP_POP, 0);
      random_items(100);
      wait_for_sender();

      send_idle = 76;
      recv_idle = 23;
      n = 0;
      while (plan_depth > 0) begin
         queue_item(OP_POP, 0);
         if (n % 13 == 0) begin
            queue_item(OP_PEEK, 0);
         end
         n++;
      end
      queue_item(OP_POP, 0);
      random_items(110);
      wait_for_sender();

      send_idle = 0;
      recv_idle = 0;
      @(posedge clock);
      holds_asked <= holds_asked + 1;
      random_items(150);

      while (accepted != queued || awaited.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", awaited.size()));
      end

      $display("covered %0d requests: %0d medians, %0d full rejects, %0d empty errors",
               accepted, medians, full_rejects, empty_errors);
      $display("peak depth %0d, %0d results checked, %0d mismatches",
               peak_depth, checked, failures);
      if (failures == 0) begin
         $display("stack_with_median_query test passed");
      end else begin
         $display("stack_with_median_query test failed");
      end
      $finish;
   end

endmodule
